// File: rtl/core/mfqs_pkg.sv
// Shared package of the multilevel feedback queue scheduler: widths, codes and the
// cell entry and cell command types. No dependencies.
package mfqs_pkg;
   localparam int THREAD_W   = 4;
   localparam int LEVEL_W    = 3;   // holds levels of up to eight queues
   localparam int POS_W      = 6;   // holds positions of up to 64 cells
   localparam int AGE_W      = 16;
   localparam int SLOT_W     = 8;
   localparam int ACTION_W   = 3;
   localparam int START_W    = 2;
   localparam int OUT_LVL_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DEF_NUM_LEVELS  = 4;
   localparam int DEF_MAX_THREADS = 16;

   localparam logic [ACTION_W-1:0] ACT_ADD       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_UPGRADE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DOWNGRADE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_KEEP      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_AGE_TICK  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTA_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTA_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTA_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTA_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_2    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_3    = 3'd6;

   localparam logic       STATUS_DONE    = 1'b0;
   localparam logic       STATUS_IGNORED = 1'b1;
   localparam logic [AGE_W-1:0] AGE_MAX  = '1;

   typedef struct packed {
      logic [THREAD_W-1:0] tid;
      logic [LEVEL_W-1:0]  level;
      logic [AGE_W-1:0]    age;
      logic [SLOT_W-1:0]   slots;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type data;
   } cell_state_type;

   typedef struct packed {
      logic             shift_en;   // cells at or after shift_pos take their right neighbour
      logic [POS_W-1:0] shift_pos;
      logic             load_en;    // load_pos takes load_data (wins over shift)
      logic [POS_W-1:0] load_pos;
      entry_type        load_data;
      logic             age_en;     // in-place age update
      logic [POS_W-1:0] age_pos;
      logic [AGE_W-1:0] age_val;
   } cell_cmd_type;
endpackage

// File: rtl/core/multilevel_feedback_queue_scheduler.sv
// Multilevel feedback queue scheduler, top level: sequencer, registers, cell chain.
// Depends on mfqs_pkg and mfqs_cell.
// Add/upgrade/downgrade/keep/remove pass through the exec and report states to the strobe.
// Age tick walks the chain once for each of levels 1..NUM_LEVELS-1, one chain position
// per cycle while no thread is promoted; a promotion holds the walk at its position.
// One word at a time; busy is high until the result strobe. Receiver cannot stall.
// Reset clears all queues and loads the register defaults; no clearing pass.
module multilevel_feedback_queue_scheduler #(
   parameter int NUM_LEVELS  = mfqs_pkg::DEF_NUM_LEVELS,
   parameter int MAX_THREADS = mfqs_pkg::DEF_MAX_THREADS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mfqs_pkg::ACTION_W-1:0]   req_action,
   input  logic [mfqs_pkg::THREAD_W-1:0]   req_thread_id,
   input  logic [mfqs_pkg::START_W-1:0]    req_start_level,
   output logic                            rsp_strobe,
   output logic                            rsp_next_valid,
   output logic [mfqs_pkg::THREAD_W-1:0]   rsp_head_thread,
   output logic [mfqs_pkg::OUT_LVL_W-1:0]  rsp_thread_level,
   output logic [mfqs_pkg::SLOT_W-1:0]     rsp_thread_slots,
   output logic                            rsp_status,
   input  logic                            csr_write_en,
   input  logic [mfqs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mfqs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mfqs_pkg::*;

   localparam int PW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);
   localparam logic [LEVEL_W-1:0] LAST_LVL = LEVEL_W'(NUM_LEVELS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_TICK   = 2'd2;
   localparam logic [1:0] ST_REPORT = 2'd3;

   // configuration registers
   logic [SLOT_W-1:0] quanta_ff [4];
   logic [AGE_W-1:0]  age_lim_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         quanta_ff[0]  <= 8'd1;
         quanta_ff[1]  <= 8'd2;
         quanta_ff[2]  <= 8'd4;
         quanta_ff[3]  <= 8'd8;
         age_lim_ff[0] <= 16'd100;
         age_lim_ff[1] <= 16'd100;
         age_lim_ff[2] <= 16'd100;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_QUANTA_0: quanta_ff[0]  <= csr_wdata[SLOT_W-1:0];
            CSR_QUANTA_1: quanta_ff[1]  <= csr_wdata[SLOT_W-1:0];
            CSR_QUANTA_2: quanta_ff[2]  <= csr_wdata[SLOT_W-1:0];
            CSR_QUANTA_3: quanta_ff[3]  <= csr_wdata[SLOT_W-1:0];
            CSR_AGE_1:    age_lim_ff[0] <= csr_wdata;
            CSR_AGE_2:    age_lim_ff[1] <= csr_wdata;
            CSR_AGE_3:    age_lim_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cell chain: cell i takes cell i+1 on a shift; the end of the chain shifts in empty
   cell_cmd_type   cmd;
   cell_state_type cells [MAX_THREADS];
   cell_state_type rights [MAX_THREADS];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_THREADS; gi++) begin : g_cell
         if (gi < MAX_THREADS - 1) begin : g_mid
            assign rights[gi] = cells[gi+1];
         end else begin : g_end
            assign rights[gi] = '0;
         end
         mfqs_cell #(.IDX(gi)) u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .right (rights[gi]),
            .cur   (cells[gi])
         );
      end
   endgenerate

   // control state
   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pos_ff, pos_in;     // tick walk position
   logic [LEVEL_W-1:0]  lvl_ff, lvl_in;     // tick walk level
   logic [ACTION_W-1:0] action_ff;
   logic [THREAD_W-1:0] tid_ff;
   logic [START_W-1:0]  start_lvl_ff;
   logic                status_ff, status_in;

   // word latch
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         action_ff    <= req_action;
         tid_ff       <= req_thread_id;
         start_lvl_ff <= req_start_level;
      end
   end

   // locate the addressed thread (at most one cell matches)
   logic          found;
   logic [PW-1:0] fpos;
   always_comb begin
      found = 1'b0;
      fpos  = '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
         if (cells[i].valid && cells[i].data.tid == tid_ff) begin
            found = 1'b1;
            fpos  = PW'(i);
         end
      end
   end

   entry_type f_e, t_e;
   assign f_e = cells[fpos].data;
   assign t_e = cells[pos_ff[PW-1:0]].data;

   // next state and chain command
   logic                move_en, add_en;
   logic [POS_W-1:0]    move_pos;
   logic [LEVEL_W-1:0]  tgt_lvl;
   logic [THREAD_W-1:0] move_tid;
   logic [1:0]          qidx;
   logic [1:0]          aidx;
   logic [AGE_W-1:0]    new_age;
   logic [LEVEL_W-1:0]  start_sat;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      lvl_in    = lvl_ff;
      status_in = status_ff;
      move_en   = 1'b0;
      add_en    = 1'b0;
      move_pos  = POS_W'(fpos);
      tgt_lvl   = '0;
      move_tid  = tid_ff;
      cmd       = '0;
      new_age   = (t_e.age == AGE_MAX) ? AGE_MAX : t_e.age + 1'b1;
      start_sat = (int'(start_lvl_ff) >= NUM_LEVELS - 1) ? LAST_LVL
                                                          : LEVEL_W'(start_lvl_ff);
      aidx      = (lvl_ff > LEVEL_W'(3)) ? 2'd2 : 2'(lvl_ff - 1'b1);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_DONE;
            state_in  = ST_REPORT;
            case (action_ff)
               ACT_ADD: begin
                  if (found || int'(tid_ff) >= MAX_THREADS) begin
                     status_in = STATUS_IGNORED;
                  end else begin
                     add_en  = 1'b1;
                     tgt_lvl = start_sat;
                  end
               end
               ACT_UPGRADE: begin
                  if (!found) begin
                     status_in = STATUS_IGNORED;
                  end else if (f_e.level != '0) begin
                     move_en = 1'b1;
                     tgt_lvl = f_e.level - 1'b1;
                  end
               end
               ACT_DOWNGRADE: begin
                  if (!found) begin
                     status_in = STATUS_IGNORED;
                  end else begin
                     move_en = 1'b1;
                     tgt_lvl = (f_e.level == LAST_LVL) ? f_e.level : f_e.level + 1'b1;
                  end
               end
               ACT_KEEP: begin
                  if (!found) begin
                     status_in = STATUS_IGNORED;
                  end else begin
                     move_en = 1'b1;
                     tgt_lvl = f_e.level;
                  end
               end
               ACT_AGE_TICK: begin
                  state_in = ST_TICK;
                  lvl_in   = LEVEL_W'(1);
                  pos_in   = '0;
               end
               ACT_REMOVE: begin
                  if (!found) begin
                     status_in = STATUS_IGNORED;
                  end else begin
                     cmd.shift_en  = 1'b1;
                     cmd.shift_pos = POS_W'(fpos);
                     count_in      = count_ff - 1'b1;
                  end
               end
               default: status_in = STATUS_IGNORED;
            endcase
         end
         ST_TICK: begin
            // walk level lvl_ff in chain order; a promoted thread goes to the tail
            // at the level above, so the walk stays at the same position
            if (pos_ff >= count_ff) begin
               pos_in = '0;
               if (lvl_ff == LAST_LVL) begin
                  state_in = ST_REPORT;
               end else begin
                  lvl_in = lvl_ff + 1'b1;
               end
            end else if (t_e.level == lvl_ff) begin
               if (new_age > age_lim_ff[aidx]) begin
                  move_en  = 1'b1;
                  move_pos = POS_W'(pos_ff[PW-1:0]);
                  tgt_lvl  = lvl_ff - 1'b1;
                  move_tid = t_e.tid;
               end else begin
                  cmd.age_en  = 1'b1;
                  cmd.age_pos = POS_W'(pos_ff[PW-1:0]);
                  cmd.age_val = new_age;
                  pos_in      = pos_ff + 1'b1;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase

      qidx = (tgt_lvl > LEVEL_W'(3)) ? 2'd3 : tgt_lvl[1:0];
      cmd.load_data.tid   = move_tid;
      cmd.load_data.level = tgt_lvl;
      cmd.load_data.age   = '0;
      cmd.load_data.slots = quanta_ff[qidx];
      if (add_en) begin
         cmd.load_en  = 1'b1;
         cmd.load_pos = POS_W'(count_ff);
         count_in     = count_ff + 1'b1;
      end
      if (move_en) begin
         cmd.shift_en  = 1'b1;
         cmd.shift_pos = move_pos;
         cmd.load_en   = 1'b1;
         cmd.load_pos  = POS_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      lvl_ff    <= lvl_in;
      status_ff <= status_in;
   end

   // head of the highest non-empty level
   logic [NUM_LEVELS-1:0] lvl_any;
   logic [LEVEL_W-1:0]    head_lvl;
   logic [THREAD_W-1:0]   head_tid;
   always_comb begin
      lvl_any  = '0;
      head_lvl = '0;
      head_tid = '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (cells[i].valid && cells[i].data.level == LEVEL_W'(l)) begin
               lvl_any[l] = 1'b1;
            end
         end
      end
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (lvl_any[l]) begin
            head_lvl = LEVEL_W'(l);
         end
      end
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (cells[i].valid && cells[i].data.level == head_lvl) begin
            head_tid = cells[i].data.tid;
         end
      end
   end

   // result word: registered, shown for one cycle
   logic                 strobe_ff;
   logic                 next_valid_ff;
   logic [THREAD_W-1:0]  head_thread_ff;
   logic [OUT_LVL_W-1:0] out_lvl_ff;
   logic [SLOT_W-1:0]    out_slots_ff;
   logic                 out_status_ff;
   logic                 show_thread;

   assign show_thread = found && status_ff == STATUS_DONE && action_ff != ACT_AGE_TICK;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == ST_REPORT);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_REPORT) begin
         next_valid_ff  <= |lvl_any;
         head_thread_ff <= head_tid;
         out_lvl_ff     <= show_thread ? f_e.level[OUT_LVL_W-1:0] : '0;
         out_slots_ff   <= show_thread ? f_e.slots : '0;
         out_status_ff  <= status_ff;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_next_valid   = next_valid_ff;
   assign rsp_head_thread  = head_thread_ff;
   assign rsp_thread_level = out_lvl_ff;
   assign rsp_thread_slots = out_slots_ff;
   assign rsp_status       = out_status_ff;

   // queued cells always form a prefix of the chain of length count
   logic [MAX_THREADS-1:0] valid_vec;
   always_comb begin
      for (int i = 0; i < MAX_THREADS; i++) begin
         valid_vec[i] = cells[i].valid;
      end
   end

   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(valid_vec))
      else $error("queue count disagrees with occupied cells");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(state_ff) == ST_REPORT)
      else $error("result strobe outside report");

   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_next_valid == (count_ff != '0))
      else $error("head valid disagrees with queue count");
endmodule

// File: rtl/core/mfqs_cell.sv
// One cell of the scheduler's queue chain: holds one queued thread word.
// Depends on mfqs_pkg.
module mfqs_cell #(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mfqs_pkg::cell_cmd_type  cmd,
   input  mfqs_pkg::cell_state_type right,
   output mfqs_pkg::cell_state_type cur
);
   import mfqs_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

   logic      valid_ff, valid_in;
   entry_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.load_en && cmd.load_pos == MY_POS) begin
         valid_in = 1'b1;
         data_in  = cmd.load_data;
      end else if (cmd.shift_en && MY_POS >= cmd.shift_pos) begin
         valid_in = right.valid;
         data_in  = right.data;
      end else if (cmd.age_en && cmd.age_pos == MY_POS) begin
         data_in.age = cmd.age_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cur.valid = valid_ff;
   assign cur.data  = data_ff;
endmodule
